[rtl/core/ppd_pkg.sv]
`default_nettype none

package ppd_pkg;

    // rotation steps; the arctangent table has 24 entries
    localparam int TRIG_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < ATAN_ENTRIES) ?
                                     TRIG_ITERATIONS : ATAN_ENTRIES;

    // port field widths
    localparam int RAD_W  = 15;
    localparam int ANG_W  = 15;
    localparam int DIST_W = 16;

    // radius in Q8, saturated at 100.0
    localparam logic [RAD_W-1:0] RADIUS_MAX = RAD_W'(25600);

    // angle turns in Q6 degrees, one bit wider and signed for the fold
    localparam int TURN_W = ANG_W + 1;
    localparam logic signed [TURN_W-1:0] QUARTER_TURN       = TURN_W'(5760);
    localparam logic signed [TURN_W-1:0] HALF_TURN          = TURN_W'(11520);
    localparam logic signed [TURN_W-1:0] THREE_QUARTER_TURN = TURN_W'(17280);
    localparam logic signed [TURN_W-1:0] FULL_TURN          = TURN_W'(23040);

    // folded angle, -90..+90 degrees in Q6
    localparam int DEG_W = 14;

    // degrees Q6 to radians Q30
    localparam int RAD_CONST_W = 20;
    localparam logic signed [RAD_CONST_W-1:0] DEG_TO_RAD = RAD_CONST_W'(292818);

    // inverse CORDIC gain in Q30, start vector in Q24
    localparam int GAIN_W     = 30;
    localparam logic [GAIN_W-1:0] INV_GAIN = GAIN_W'(652032874);
    localparam int GAIN_SHIFT = 14;
    localparam int X0_W       = RAD_W + GAIN_W;

    // rotation datapath
    localparam int XY_W = 34;
    localparam int Z_W  = DEG_W + RAD_CONST_W;

    // difference, rounding to Q16, squares and root
    localparam int DIFF_W      = XY_W + 1;
    localparam int ROUND_SHIFT = 8;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int ROOT_W      = (SUM_W + 1) / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int RADICAND_W  = 2 * ROOT_W;

    // front stages, rotation steps, four distance stages, root steps, output
    localparam int LATENCY = 2 + CORDIC_STEPS + 4 + ROOT_W + 1;
    // items the block can hold, counting the skid register
    localparam int SLOTS   = LATENCY + 1;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   flip;
    } cordic_lane_t;

    typedef cordic_lane_t [1:0] lane_pair_t;

    // arctangent of 2^-i in Q30 radians
    function automatic logic signed [Z_W-1:0] atan_q30(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = Z_W'(32'h3243F6A8);
            1:       v = Z_W'(32'h1DAC6705);
            2:       v = Z_W'(32'h0FADBAFC);
            3:       v = Z_W'(32'h07F56EA6);
            4:       v = Z_W'(32'h03FEAB76);
            5:       v = Z_W'(32'h01FFD55B);
            6:       v = Z_W'(32'h00FFFAAA);
            7:       v = Z_W'(32'h007FFF55);
            8:       v = Z_W'(32'h003FFFEA);
            9:       v = Z_W'(32'h001FFFFD);
            10:      v = Z_W'(32'h000FFFFF);
            11:      v = Z_W'(32'h0007FFFF);
            12:      v = Z_W'(32'h0003FFFF);
            13:      v = Z_W'(32'h0001FFFF);
            14:      v = Z_W'(32'h0000FFFF);
            15:      v = Z_W'(32'h00007FFF);
            16:      v = Z_W'(32'h00003FFF);
            17:      v = Z_W'(32'h00001FFF);
            18:      v = Z_W'(32'h00000FFF);
            19:      v = Z_W'(32'h000007FF);
            20:      v = Z_W'(32'h000003FF);
            21:      v = Z_W'(32'h000001FF);
            22:      v = Z_W'(32'h000000FF);
            23:      v = Z_W'(32'h0000007F);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ppd_pair_if.sv]
`default_nettype none

interface ppd_pair_if;
    logic                      valid;
    logic                      ready;
    logic [ppd_pkg::RAD_W-1:0] radius_a;
    logic [ppd_pkg::ANG_W-1:0] angle_a;
    logic [ppd_pkg::RAD_W-1:0] radius_b;
    logic [ppd_pkg::ANG_W-1:0] angle_b;

    modport source (output valid, radius_a, angle_a, radius_b, angle_b, input ready);
    modport sink   (input valid, radius_a, angle_a, radius_b, angle_b, output ready);
endinterface

`default_nettype wire

[rtl/core/ppd_result_if.sv]
`default_nettype none

interface ppd_result_if;
    logic                       valid;
    logic                       ready;
    logic [ppd_pkg::DIST_W-1:0] distance;

    modport source (output valid, distance, input ready);
    modport sink   (input valid, distance, output ready);
endinterface

`default_nettype wire

[rtl/core/ppd_front.sv]
`default_nettype none

module ppd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [ppd_pkg::RAD_W-1:0] radius_a,
    input  wire logic [ppd_pkg::ANG_W-1:0] angle_a,
    input  wire logic [ppd_pkg::RAD_W-1:0] radius_b,
    input  wire logic [ppd_pkg::ANG_W-1:0] angle_b,
    output logic                           out_valid,
    output ppd_pkg::lane_pair_t            lanes
);

    typedef struct packed {
        logic [ppd_pkg::RAD_W-1:0]        r;
        logic signed [ppd_pkg::DEG_W-1:0] d;
        logic                             flip;
    } front_pt_t;

    logic [ppd_pkg::RAD_W-1:0] rad_in [2];
    logic [ppd_pkg::ANG_W-1:0] ang_in [2];

    front_pt_t pt_next [2];
    front_pt_t pt_reg  [2];
    logic      valid1_reg;

    ppd_pkg::lane_pair_t lanes_next;
    ppd_pkg::lane_pair_t lanes_reg;
    logic                valid2_reg;

    assign rad_in[0] = radius_a;
    assign rad_in[1] = radius_b;
    assign ang_in[0] = angle_a;
    assign ang_in[1] = angle_b;

    // saturate radius, wrap angle once, fold into -90..+90 degrees
    always_comb
    begin
        logic signed [ppd_pkg::TURN_W-1:0] a_s;
        logic signed [ppd_pkg::TURN_W-1:0] d_s;
        for (int p = 0; p < 2; p++)
        begin
            pt_next[p].r = (rad_in[p] > ppd_pkg::RADIUS_MAX) ? ppd_pkg::RADIUS_MAX : rad_in[p];
            a_s = signed'({1'b0, ang_in[p]});
            if (a_s >= ppd_pkg::FULL_TURN)
            begin
                a_s = a_s - ppd_pkg::FULL_TURN;
            end
            pt_next[p].flip = 1'b0;
            if ((a_s > ppd_pkg::QUARTER_TURN) && (a_s < ppd_pkg::THREE_QUARTER_TURN))
            begin
                d_s             = a_s - ppd_pkg::HALF_TURN;
                pt_next[p].flip = 1'b1;
            end
            else if (a_s >= ppd_pkg::THREE_QUARTER_TURN)
            begin
                d_s = a_s - ppd_pkg::FULL_TURN;
            end
            else
            begin
                d_s = a_s;
            end
            pt_next[p].d = ppd_pkg::DEG_W'(d_s);
        end
    end

    // angle to radians and scaled start vector
    always_comb
    begin
        logic signed [ppd_pkg::Z_W-1:0] zp;
        logic [ppd_pkg::X0_W-1:0]       xp;
        for (int p = 0; p < 2; p++)
        begin
            zp = pt_reg[p].d * ppd_pkg::DEG_TO_RAD;
            xp = pt_reg[p].r * ppd_pkg::INV_GAIN;
            lanes_next[p].z    = zp;
            lanes_next[p].x    = ppd_pkg::XY_W'(xp[ppd_pkg::X0_W-1:ppd_pkg::GAIN_SHIFT]);
            lanes_next[p].y    = '0;
            lanes_next[p].flip = pt_reg[p].flip;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg    <= pt_next;
            lanes_reg <= lanes_next;
        end
    end

    assign out_valid = valid2_reg;
    assign lanes     = lanes_reg;

endmodule

`default_nettype wire

[rtl/core/ppd_cordic.sv]
`default_nettype none

module ppd_cordic (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire ppd_pkg::lane_pair_t lanes_in,
    output logic                     out_valid,
    output ppd_pkg::lane_pair_t      lanes_out
);

    ppd_pkg::lane_pair_t step_reg   [ppd_pkg::CORDIC_STEPS];
    logic                valid_reg  [ppd_pkg::CORDIC_STEPS];

    // one rotation step per register stage, both points side by side
    for (genvar k = 0; k < ppd_pkg::CORDIC_STEPS; k++)
    begin : g_step
        ppd_pkg::lane_pair_t cur;
        ppd_pkg::lane_pair_t step_next;
        logic                cur_valid;

        if (k == 0)
        begin : g_first
            assign cur       = lanes_in;
            assign cur_valid = in_valid;
        end
        else
        begin : g_chain
            assign cur       = step_reg[k-1];
            assign cur_valid = valid_reg[k-1];
        end

        // rotate toward zero residual angle
        always_comb
        begin
            for (int p = 0; p < 2; p++)
            begin
                step_next[p] = cur[p];
                if (!cur[p].z[ppd_pkg::Z_W-1])
                begin
                    step_next[p].x = cur[p].x - (cur[p].y >>> k);
                    step_next[p].y = cur[p].y + (cur[p].x >>> k);
                    step_next[p].z = cur[p].z - ppd_pkg::atan_q30(k);
                end
                else
                begin
                    step_next[p].x = cur[p].x + (cur[p].y >>> k);
                    step_next[p].y = cur[p].y - (cur[p].x >>> k);
                    step_next[p].z = cur[p].z + ppd_pkg::atan_q30(k);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                step_reg[k] <= step_next;
            end
        end
    end

    assign out_valid = valid_reg[ppd_pkg::CORDIC_STEPS-1];
    assign lanes_out = step_reg[ppd_pkg::CORDIC_STEPS-1];

endmodule

`default_nettype wire

[rtl/core/ppd_sumsq.sv]
`default_nettype none

module ppd_sumsq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire ppd_pkg::lane_pair_t       lanes_in,
    output logic                           out_valid,
    output logic [ppd_pkg::SUM_W-1:0]      sum
);

    localparam logic signed [ppd_pkg::DIFF_W-1:0] ROUND_HALF =
        ppd_pkg::DIFF_W'(1 << (ppd_pkg::ROUND_SHIFT - 1));

    logic signed [ppd_pkg::XY_W-1:0]   xa, ya, xb, yb;
    logic signed [ppd_pkg::DIFF_W-1:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [ppd_pkg::MAG_W-1:0]         mx_next, my_next, mx_reg, my_reg;
    logic [ppd_pkg::SQ_W-1:0]          sqx_next, sqy_next, sqx_reg, sqy_reg;
    logic [ppd_pkg::SUM_W-1:0]         sum_next, sum_reg;
    logic                              v1_reg, v2_reg, v3_reg, v4_reg;

    // round Q24 to Q16 to nearest, half up, then magnitude
    function automatic logic [ppd_pkg::MAG_W-1:0] round_mag(
        input logic signed [ppd_pkg::DIFF_W-1:0] v
    );
        logic signed [ppd_pkg::DIFF_W-1:0] t;
        logic signed [ppd_pkg::DIFF_W-1:0] m;
        t = (v + ROUND_HALF) >>> ppd_pkg::ROUND_SHIFT;
        m = t[ppd_pkg::DIFF_W-1] ? -t : t;
        return m[ppd_pkg::MAG_W-1:0];
    endfunction

    // undo the half-turn fold and take the differences
    always_comb
    begin
        xa = lanes_in[0].flip ? -lanes_in[0].x : lanes_in[0].x;
        ya = lanes_in[0].flip ? -lanes_in[0].y : lanes_in[0].y;
        xb = lanes_in[1].flip ? -lanes_in[1].x : lanes_in[1].x;
        yb = lanes_in[1].flip ? -lanes_in[1].y : lanes_in[1].y;
        dx_next = ppd_pkg::DIFF_W'(xb) - ppd_pkg::DIFF_W'(xa);
        dy_next = ppd_pkg::DIFF_W'(yb) - ppd_pkg::DIFF_W'(ya);
    end

    // rounding, squares, sum
    always_comb
    begin
        mx_next  = round_mag(dx_reg);
        my_next  = round_mag(dy_reg);
        sqx_next = mx_reg * mx_reg;
        sqy_next = my_reg * my_reg;
        sum_next = ppd_pkg::SUM_W'(sqx_reg) + ppd_pkg::SUM_W'(sqy_reg);
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            mx_reg  <= mx_next;
            my_reg  <= my_next;
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            sum_reg <= sum_next;
        end
    end

    assign out_valid = v4_reg;
    assign sum       = sum_reg;

endmodule

`default_nettype wire

[rtl/core/ppd_isqrt.sv]
`default_nettype none

module ppd_isqrt (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [ppd_pkg::SUM_W-1:0]    sum,
    output logic                              out_valid,
    output logic [ppd_pkg::ROOT_W-1:0]        root
);

    typedef struct packed {
        logic [ppd_pkg::RADICAND_W-1:0] rad;
        logic [ppd_pkg::REM_W-1:0]      rem;
        logic [ppd_pkg::ROOT_W-1:0]     q;
    } sqrt_stage_t;

    sqrt_stage_t step_reg  [ppd_pkg::ROOT_W];
    logic        valid_reg [ppd_pkg::ROOT_W];

    // one root bit per stage, restoring digit recurrence
    for (genvar k = 0; k < ppd_pkg::ROOT_W; k++)
    begin : g_bit
        sqrt_stage_t               cur;
        sqrt_stage_t               step_next;
        logic                      cur_valid;
        logic [ppd_pkg::REM_W-1:0] cur_rem;
        logic [ppd_pkg::REM_W-1:0] trial;

        if (k == 0)
        begin : g_first
            assign cur.rad   = ppd_pkg::RADICAND_W'(sum);
            assign cur.rem   = '0;
            assign cur.q     = '0;
            assign cur_valid = in_valid;
        end
        else
        begin : g_chain
            assign cur       = step_reg[k-1];
            assign cur_valid = valid_reg[k-1];
        end

        // bring down two radicand bits, try q*4+1
        always_comb
        begin
            cur_rem = {cur.rem[ppd_pkg::REM_W-3:0], cur.rad[ppd_pkg::RADICAND_W-1 -: 2]};
            trial   = ppd_pkg::REM_W'({cur.q, 2'b01});
            step_next.rad = {cur.rad[ppd_pkg::RADICAND_W-3:0], 2'b00};
            if (cur_rem >= trial)
            begin
                step_next.rem = cur_rem - trial;
                step_next.q   = {cur.q[ppd_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                step_next.rem = cur_rem;
                step_next.q   = {cur.q[ppd_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                step_reg[k] <= step_next;
            end
        end
    end

    assign out_valid = valid_reg[ppd_pkg::ROOT_W-1];
    assign root      = step_reg[ppd_pkg::ROOT_W-1].q;

endmodule

`default_nettype wire

[rtl/core/polar_point_distance_top.sv]
// throughput: one pair per cycle while the skid word is free; the pipeline holds one rotation stage per CORDIC step
//   and one stage per root bit, with a skid word behind the output register
// a stalled result freezes the pipeline one word later; nothing is dropped or repeated
// reset: asynchronous, active low; clears all valid bits, no clearing pass
`default_nettype none

module polar_point_distance_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ppd_pair_if.sink       pair,
    ppd_result_if.source   result
);

    localparam int DQ_W = ppd_pkg::ROOT_W + 1 - ppd_pkg::ROUND_SHIFT;
    localparam logic [ppd_pkg::ROOT_W:0] ROOT_HALF =
        (ppd_pkg::ROOT_W + 1)'(1 << (ppd_pkg::ROUND_SHIFT - 1));

    logic                          en;
    logic                          front_valid, cordic_valid, sumsq_valid, root_valid;
    ppd_pkg::lane_pair_t           front_lanes, cordic_lanes;
    logic [ppd_pkg::SUM_W-1:0]     sum;
    logic [ppd_pkg::ROOT_W-1:0]    root;
    logic [ppd_pkg::ROOT_W:0]      root_rnd;
    logic [DQ_W-1:0]               dq;
    logic [ppd_pkg::DIST_W-1:0]    dist_calc;

    logic                          out_free;
    logic                          out_valid_reg, out_valid_next;
    logic [ppd_pkg::DIST_W-1:0]    out_dist_reg, out_dist_next;
    logic                          skid_valid_reg, skid_valid_next;
    logic [ppd_pkg::DIST_W-1:0]    skid_dist_reg, skid_dist_next;

    // whole pipeline advances while the skid word is free
    assign en         = !skid_valid_reg;
    assign pair.ready = en;

    ppd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pair.valid),
        .radius_a  (pair.radius_a),
        .angle_a   (pair.angle_a),
        .radius_b  (pair.radius_b),
        .angle_b   (pair.angle_b),
        .out_valid (front_valid),
        .lanes     (front_lanes)
    );

    ppd_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .lanes_in  (front_lanes),
        .out_valid (cordic_valid),
        .lanes_out (cordic_lanes)
    );

    ppd_sumsq u_sumsq (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cordic_valid),
        .lanes_in  (cordic_lanes),
        .out_valid (sumsq_valid),
        .sum       (sum)
    );

    ppd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sumsq_valid),
        .sum       (sum),
        .out_valid (root_valid),
        .root      (root)
    );

    // round Q16 root to Q8 and saturate
    always_comb
    begin
        root_rnd  = (ppd_pkg::ROOT_W + 1)'(root) + ROOT_HALF;
        dq        = root_rnd[ppd_pkg::ROOT_W:ppd_pkg::ROUND_SHIFT];
        dist_calc = (|dq[DQ_W-1:ppd_pkg::DIST_W]) ? '1 : dq[ppd_pkg::DIST_W-1:0];
    end

    // output register with skid word
    always_comb
    begin
        out_free        = !out_valid_reg || result.ready;
        out_valid_next  = out_valid_reg;
        out_dist_next   = out_dist_reg;
        skid_valid_next = skid_valid_reg;
        skid_dist_next  = skid_dist_reg;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_dist_next   = skid_dist_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            out_valid_next = root_valid;
            out_dist_next  = dist_calc;
        end
        else if (root_valid)
        begin
            skid_valid_next = 1'b1;
            skid_dist_next  = dist_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg  <= out_dist_next;
        skid_dist_reg <= skid_dist_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;

endmodule

`default_nettype wire

[rtl/core/ppd_checker.sv]
`default_nettype none

module ppd_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       pair_valid,
    input wire logic                       pair_ready,
    input wire logic                       result_valid,
    input wire logic                       result_ready,
    input wire logic [ppd_pkg::DIST_W-1:0] distance
);

    localparam int CNT_W = $clog2(ppd_pkg::SLOTS + 1);

    logic             in_acc, out_acc;
    logic [CNT_W-1:0] outstanding_reg, outstanding_next;

    // words accepted but not yet delivered
    assign in_acc           = pair_valid && pair_ready;
    assign out_acc          = result_valid && result_ready;
    assign outstanding_next = outstanding_reg + CNT_W'(in_acc) - CNT_W'(out_acc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // a stalled result word holds its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(distance))
        else $error("result word changed while stalled");

    // every result word belongs to an accepted pair
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> outstanding_reg != '0)
        else $error("result word without an accepted pair");

    // an empty output register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> pair_ready)
        else $error("input stalled with empty output");

    // words in flight never exceed the pipeline capacity
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= CNT_W'(ppd_pkg::SLOTS))
        else $error("more words in flight than pipeline slots");

endmodule

bind polar_point_distance_top ppd_checker u_ppd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pair_valid   (pair.valid),
    .pair_ready   (pair.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .distance     (result.distance)
);

`default_nettype wire

[tb/sv/polar_point_distance_top_tb.sv]
`default_nettype none

module polar_point_distance_top_tb;

    import ppd_pkg::*;

    // run shape
    localparam int HOLD_CYCLES  = 4 * SLOTS;
    localparam int QUIET_LIMIT  = 20 * SLOTS;
    localparam int MAX_REPORTS  = 40;
    localparam int IDLE_PCT     = 20;
    localparam int PHASE_A      = 200;
    localparam int PHASE_B      = 150;
    localparam int PHASE_FILL   = 80;
    localparam int PHASE_D      = 200;
    localparam int DIR_ROWS     = 18;
    localparam bit TYPED        = 1'b1;
    localparam bit PREDICTED    = 1'b0;

    typedef struct packed {
        logic [RAD_W-1:0] radius_a;
        logic [ANG_W-1:0] angle_a;
        logic [RAD_W-1:0] radius_b;
        logic [ANG_W-1:0] angle_b;
    } pair_t;

    typedef struct packed {
        pair_t             pair;
        logic              typed;
        logic [DIST_W-1:0] distance;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ppd_pair_if   pair_if ();
    ppd_result_if result_if ();

    polar_point_distance_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair_if),
        .result (result_if)
    );

    // arctangent of 2^-i, Q30 radians
    longint atan_tbl [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
        64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
        64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // directed pairs; typed rows have an obvious answer, the rest go through the predictor
    dir_row_t dir_rows [DIR_ROWS] = '{
        // all zero
        '{'{15'd0,     15'd0,     15'd0,     15'd0},     TYPED,     16'd0},
        // same point twice
        '{'{15'd25600, 15'd0,     15'd25600, 15'd0},     TYPED,     16'd0},
        '{'{15'd12345, 15'd8000,  15'd12345, 15'd8000},  TYPED,     16'd0},
        // radius over 100 saturates
        '{'{15'd32767, 15'd0,     15'd25600, 15'd0},     TYPED,     16'd0},
        // angle at a full turn wraps to zero
        '{'{15'd25600, 15'd23040, 15'd25600, 15'd0},     TYPED,     16'd0},
        '{'{15'd25600, 15'd32767, 15'd25600, 15'd9727},  TYPED,     16'd0},
        // zero radius, angle does not matter
        '{'{15'd0,     15'd32767, 15'd0,     15'd5761},  TYPED,     16'd0},
        '{'{15'd25600, 15'd0,     15'd0,     15'd0},     PREDICTED, 16'd0},
        // opposite points, far side of the fold, then other predicted pairs
        '{'{15'd25600, 15'd0,     15'd25600, 15'd11520}, PREDICTED, 16'd0},
        '{'{15'd25600, 15'd5760,  15'd25600, 15'd17280}, PREDICTED, 16'd0},
        '{'{15'd25600, 15'd5761,  15'd25600, 15'd17279}, PREDICTED, 16'd0},
        '{'{15'd25600, 15'd5759,  15'd25600, 15'd17281}, PREDICTED, 16'd0},
        '{'{15'd25600, 15'd11519, 15'd25600, 15'd11521}, PREDICTED, 16'd0},
        '{'{15'd25600, 15'd23039, 15'd25600, 15'd1},     PREDICTED, 16'd0},
        '{'{15'd1,     15'd1,     15'd1,     15'd2},     PREDICTED, 16'd0},
        '{'{15'd32767, 15'd16383, 15'd32767, 15'd16384}, PREDICTED, 16'd0},
        '{'{15'd21845, 15'd10922, 15'd10922, 15'd21845}, PREDICTED, 16'd0},
        '{'{15'd32767, 15'd24000, 15'd16384, 15'd30000}, PREDICTED, 16'd0}
    };

    logic [DIST_W-1:0] distance_q [$];
    int mismatches;
    int source_idle_pct;
    int sink_idle_pct;
    int hold_tickets;
    int holds_started;
    int hold_left;
    int quiet_cycles;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // polar point to Q24 x and y
    function automatic void polar_to_xy(input logic [RAD_W-1:0] r_in,
                                        input logic [ANG_W-1:0] a_in,
                                        output longint x, output longint y);
        longint r;
        longint d;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        r    = longint'(r_in);
        d    = longint'(a_in);
        flip = 1'b0;
        if (r > longint'(RADIUS_MAX))
            r = longint'(RADIUS_MAX);
        if (d >= longint'(FULL_TURN))
            d -= longint'(FULL_TURN);
        // fold into -90..+90 degrees
        if (d > longint'(QUARTER_TURN) && d < longint'(THREE_QUARTER_TURN))
        begin
            d -= longint'(HALF_TURN);
            flip = 1'b1;
        end
        else if (d >= longint'(THREE_QUARTER_TURN))
            d -= longint'(FULL_TURN);
        z = d * longint'(DEG_TO_RAD);
        x = (r * longint'(INV_GAIN)) >>> GAIN_SHIFT;
        y = 0;
        // rotation steps
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_tbl[i];
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_tbl[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
    endfunction

    // floor of the square root
    function automatic longint unsigned isqrt_floor(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v  -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // expected distance for one pair
    function automatic logic [DIST_W-1:0] pair_distance(input pair_t p);
        longint xa;
        longint ya;
        longint xb;
        longint yb;
        longint dx;
        longint dy;
        longint unsigned root;
        polar_to_xy(p.radius_a, p.angle_a, xa, ya);
        polar_to_xy(p.radius_b, p.angle_b, xb, yb);
        dx = (xb - xa + 128) >>> ROUND_SHIFT;
        dy = (yb - ya + 128) >>> ROUND_SHIFT;
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        root = isqrt_floor(longint'(dx * dx) + longint'(dy * dy));
        root = (root + 128) >> ROUND_SHIFT;
        if (root > 65535)
            root = 65535;
        return DIST_W'(root);
    endfunction

    function automatic logic [RAD_W-1:0] corner_radius();
        case ($urandom_range(4))
            0:       return RAD_W'(0);
            1:       return RAD_W'(1);
            2:       return RAD_W'(25599);
            3:       return RADIUS_MAX;
            default: return RAD_W'(32767);
        endcase
    endfunction

    // angles around the fold and wrap boundaries
    function automatic logic [ANG_W-1:0] corner_angle();
        case ($urandom_range(9))
            0:       return ANG_W'(0);
            1:       return ANG_W'(5759);
            2:       return ANG_W'(5760);
            3:       return ANG_W'(5761);
            4:       return ANG_W'(11520);
            5:       return ANG_W'(17279);
            6:       return ANG_W'(17280);
            7:       return ANG_W'(17281);
            8:       return ANG_W'(23039);
            default: return ANG_W'(23040);
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        int    kind;
        kind = $urandom_range(99);
        if (kind < 70)
        begin
            p.radius_a = RAD_W'($urandom_range(25600));
            p.angle_a  = ANG_W'($urandom_range(23039));
            p.radius_b = RAD_W'($urandom_range(25600));
            p.angle_b  = ANG_W'($urandom_range(23039));
        end
        else if (kind < 85)
        begin
            p.radius_a = RAD_W'($urandom_range(32767));
            p.angle_a  = ANG_W'($urandom_range(32767));
            p.radius_b = RAD_W'($urandom_range(32767));
            p.angle_b  = ANG_W'($urandom_range(32767));
        end
        else if (kind < 95)
        begin
            p.radius_a = corner_radius();
            p.angle_a  = corner_angle();
            p.radius_b = corner_radius();
            p.angle_b  = corner_angle();
        end
        else
        begin
            // coincident points
            p.radius_a = RAD_W'($urandom_range(32767));
            p.angle_a  = ANG_W'($urandom_range(32767));
            p.radius_b = p.radius_a;
            p.angle_b  = p.angle_a;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [DIST_W-1:0] got,
                                   input logic [DIST_W-1:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch: %s, got %0d, want %0d, at %0t", what, got, want, $time);
    endtask

    // offer one pair and wait for the handshake
    task automatic send_pair(input pair_t p, input logic typed, input logic [DIST_W-1:0] want);
        while ($urandom_range(99) < source_idle_pct)
        begin
            pair_if.valid <= 1'b0;
            @(posedge clk);
        end
        pair_if.valid    <= 1'b1;
        pair_if.radius_a <= p.radius_a;
        pair_if.angle_a  <= p.angle_a;
        pair_if.radius_b <= p.radius_b;
        pair_if.angle_b  <= p.angle_b;
        @(posedge clk);
        while (!pair_if.ready)
            @(posedge clk);
        distance_q.push_back(typed ? want : pair_distance(p));
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++)
            send_pair(random_pair(), PREDICTED, '0);
    endtask

    // result side: check accepted words, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (distance_q.size() == 0)
                report_mismatch("distance word with none expected", result_if.distance, '0);
            else if (result_if.distance !== distance_q[0])
            begin
                report_mismatch("distance", result_if.distance, distance_q[0]);
                void'(distance_q.pop_front());
            end
            else
                void'(distance_q.pop_front());
        end
        // long hold-off when asked, else random stalls
        if (hold_left > 0)
        begin
            hold_left--;
            result_if.ready <= 1'b0;
        end
        else if (hold_tickets != holds_started)
        begin
            holds_started++;
            hold_left = HOLD_CYCLES - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((pair_if.valid && pair_if.ready) || (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        rst_n            = 1'b0;
        pair_if.valid    = 1'b0;
        pair_if.radius_a = '0;
        pair_if.angle_a  = '0;
        pair_if.radius_b = '0;
        pair_if.angle_b  = '0;
        result_if.ready  = 1'b0;
        mismatches       = 0;
        source_idle_pct  = IDLE_PCT;
        sink_idle_pct    = IDLE_PCT;
        hold_tickets     = 0;
        holds_started    = 0;
        hold_left        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].distance);

        // random with idling on both sides
        send_random(PHASE_A);

        // back to back, no idling
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        send_random(PHASE_B);

        // result side holds off while pairs keep coming, so the pipe fills and stalls
        hold_tickets++;
        send_random(PHASE_FILL);

        // pause until the pipe has drained
        pair_if.valid <= 1'b0;
        while (distance_q.size() != 0)
            @(posedge clk);

        source_idle_pct = IDLE_PCT;
        sink_idle_pct   = IDLE_PCT;
        send_random(PHASE_D);
        pair_if.valid <= 1'b0;

        // drain, then watch for stray words
        while (distance_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
